### sv/bcu_pkg.sv
// Shared request/response types for the binomial coefficient unit.
package bcu_pkg;

    localparam int COEF_W = 64;
    localparam int FIELD_W = 16;

    typedef struct packed {
        logic [FIELD_W-1:0] set_size;
        logic [FIELD_W-1:0] choose_count;
    } t_bcu_req;

    typedef struct packed {
        logic [COEF_W-1:0] coefficient;
        logic              overflowed;
    } t_bcu_rsp;

endpackage

### sv/bcu_div.sv
// Shared restoring divider: one quotient bit per cycle, narrow or 64-bit dividend.
module bcu_div
    import bcu_pkg::*;
#(
    parameter int ARG_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_wide,
    input  logic [COEF_W-1:0]   i_dividend,
    input  logic [ARG_BITS-1:0] i_divisor,
    output logic                o_done,
    output logic [COEF_W-1:0]   o_quotient,
    output logic [ARG_BITS-1:0] o_remainder
);

    localparam int CNT_W = $clog2(COEF_W + 1);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [COEF_W-1:0]   r_quo;
    logic [ARG_BITS-1:0] r_rem;
    logic [ARG_BITS-1:0] r_dvs;

    logic [ARG_BITS:0]   w_rem_sh;
    logic                w_ge;
    logic [ARG_BITS:0]   w_diff;

    assign w_rem_sh = {r_rem, r_quo[COEF_W-1]};
    assign w_ge     = w_rem_sh >= {1'b0, r_dvs};
    assign w_diff   = w_rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
                if (i_wide) begin
                    r_quo <= i_dividend;
                    r_cnt <= CNT_W'(COEF_W);
                end else begin
                    // left-align the narrow dividend so quotient lands in low bits
                    r_quo <= {i_dividend[ARG_BITS-1:0], {(COEF_W-ARG_BITS){1'b0}}};
                    r_cnt <= CNT_W'(ARG_BITS);
                end
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[ARG_BITS-1:0] : w_rem_sh[ARG_BITS-1:0];
                r_quo <= {r_quo[COEF_W-2:0], w_ge};
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

### sv/binomial_coefficient_unit.sv
// Binomial coefficient unit: sequencer around a shared divider and a split multiplier.
//
// Requests arrive on i_req with i_in_valid; one is taken at an edge where
// i_in_valid is high and o_in_stall is low. o_in_stall is high for the whole
// time an item is being worked on. Each request gives one response on o_rsp
// with o_out_valid, taken at an edge where i_out_stall is low.
// The low ARG_BITS bits of each input field are used. For r' = min(r, k-r)
// the item runs r' steps; each step is a Euclid gcd (one or more narrow
// divides), two narrow divides, one 64-bit divide of the running value and
// a split multiply (low half, high half, add). All divides go through one
// bit-serial divider. The item takes no steps when r' is zero or r exceeds
// k; overflow ends the item early.
// One request at a time: the next is taken the cycle after the result is
// registered. The response sits in an output register; if the receiver
// stalls, the next finished result waits until that register frees. Reset
// empties the output register and returns the sequencer to idle.
module binomial_coefficient_unit
    import bcu_pkg::*;
#(
    parameter int ARG_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_bcu_req i_req,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_bcu_rsp o_rsp
);

    localparam int AB = ARG_BITS;
    localparam int PW = COEF_W + ARG_BITS;
    localparam int HW = COEF_W / 2;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_GCD_GO, S_GCD_W, S_DT_GO, S_DT_W,
        S_DI_GO, S_DI_W, S_DA_GO, S_DA_W, S_MUL_LO, S_MUL_HI, S_MUL_ADD, S_DONE
    } t_state;

    t_state          r_state;
    logic [AB-1:0]   r_k, r_lim, r_step, r_term, r_idx, r_x, r_y;
    logic [COEF_W-1:0] r_acc;
    logic            r_ovf;
    logic [HW+AB-1:0] r_plo, r_phi;
    logic            r_out_valid;
    t_bcu_rsp        r_rsp;

    logic [AB-1:0]   w_k, w_r, w_rc;
    logic [PW-1:0]   w_prod;
    logic            w_div_start, w_div_wide, w_div_done;
    logic [COEF_W-1:0] w_div_dvd, w_div_quo;
    logic [AB-1:0]   w_div_dvs, w_div_rem;
    logic            w_rsp_load;

    assign w_k    = AB'(i_req.set_size);
    assign w_r    = AB'(i_req.choose_count);
    assign w_rc   = w_k - w_r;
    assign w_prod = {r_phi, {HW{1'b0}}} + {{HW{1'b0}}, r_plo};

    assign w_rsp_load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    assign w_div_start = (r_state == S_GCD_GO) || (r_state == S_DT_GO) ||
                         (r_state == S_DI_GO) || (r_state == S_DA_GO);

    always_comb begin
        w_div_wide = 1'b0;
        w_div_dvd  = {{(COEF_W-AB){1'b0}}, r_x};
        w_div_dvs  = r_y;
        case (r_state)
            S_DT_GO: begin
                w_div_dvd = {{(COEF_W-AB){1'b0}}, r_term};
                w_div_dvs = r_x;
            end
            S_DI_GO: begin
                w_div_dvd = {{(COEF_W-AB){1'b0}}, r_idx};
                w_div_dvs = r_x;
            end
            S_DA_GO: begin
                w_div_wide = 1'b1;
                w_div_dvd  = r_acc;
                w_div_dvs  = r_idx;
            end
            default: ;
        endcase
    end

    bcu_div #(.ARG_BITS(ARG_BITS)) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_wide      (w_div_wide),
        .i_dividend  (w_div_dvd),
        .i_divisor   (w_div_dvs),
        .o_done      (w_div_done),
        .o_quotient  (w_div_quo),
        .o_remainder (w_div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_rsp_load) r_out_valid <= 1'b1;
            else if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_in_valid) begin
                    r_k    <= w_k;
                    r_acc  <= {{(COEF_W-1){1'b0}}, 1'b1};
                    r_ovf  <= 1'b0;
                    r_step <= AB'(1);
                    r_lim  <= (w_r > w_rc) ? w_rc : w_r;
                    if (w_r > w_k) begin
                        r_acc   <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_step > r_lim) begin
                        r_state <= S_DONE;
                    end else begin
                        r_term  <= r_k - r_step + AB'(1);
                        r_x     <= r_k - r_step + AB'(1);
                        r_idx   <= r_step;
                        r_y     <= r_step;
                        r_state <= S_GCD_GO;
                    end
                end
                S_GCD_GO: r_state <= S_GCD_W;
                S_GCD_W: if (w_div_done) begin
                    r_x <= r_y;
                    r_y <= w_div_rem;
                    // zero remainder: the gcd is the old divisor, now in r_x
                    r_state <= (w_div_rem == '0) ? S_DT_GO : S_GCD_GO;
                end
                S_DT_GO: r_state <= S_DT_W;
                S_DT_W: if (w_div_done) begin
                    r_term  <= w_div_quo[AB-1:0];
                    r_state <= S_DI_GO;
                end
                S_DI_GO: r_state <= S_DI_W;
                S_DI_W: if (w_div_done) begin
                    r_idx   <= w_div_quo[AB-1:0];
                    r_state <= S_DA_GO;
                end
                S_DA_GO: r_state <= S_DA_W;
                S_DA_W: if (w_div_done) begin
                    r_acc   <= w_div_quo;
                    r_state <= S_MUL_LO;
                end
                S_MUL_LO: begin
                    r_plo   <= r_acc[HW-1:0] * r_term;
                    r_state <= S_MUL_HI;
                end
                S_MUL_HI: begin
                    r_phi   <= r_acc[COEF_W-1:HW] * r_term;
                    r_state <= S_MUL_ADD;
                end
                S_MUL_ADD: begin
                    if (|w_prod[PW-1:COEF_W]) begin
                        r_acc   <= '1;
                        r_ovf   <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_acc   <= w_prod[COEF_W-1:0];
                        r_step  <= r_step + AB'(1);
                        r_state <= S_CHECK;
                    end
                end
                S_DONE: if (w_rsp_load) begin
                    r_rsp.coefficient <= r_acc;
                    r_rsp.overflowed  <= r_ovf;
                    r_state           <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_rsp       = r_rsp;

`ifndef NO_ASSERTIONS
    a_ovf_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_rsp.overflowed |-> &o_rsp.coefficient)
        else $error("overflow response without all-ones coefficient");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("unit not busy after taking a request");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_GCD_W || r_state == S_DT_W ||
                        r_state == S_DI_W || r_state == S_DA_W))
        else $error("divider finished outside a wait state");
`endif

endmodule

### test/binomial_coefficient_unit_checker.sv
// Checker for the binomial coefficient unit: predicts each response and compares it.
module binomial_coefficient_unit_checker
    import bcu_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_stall,
    input  t_bcu_req i_req,
    input  logic     i_out_valid,
    input  logic     i_out_stall,
    input  t_bcu_rsp i_rsp,
    output int       o_errors,
    output int       o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ARG_BITS = 16;
    localparam logic [63:0] ALL_ONES = '1;

    t_bcu_rsp coef_q[$];

    function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
        logic [63:0] rem;
        while (y != 0) begin
            rem = x % y;
            x = y;
            y = rem;
        end
        return x;
    endfunction

    function automatic t_bcu_rsp binom(t_bcu_req rq);
        t_bcu_rsp    rs;
        logic [63:0] k;
        logic [63:0] r;
        logic [63:0] acc;
        logic [63:0] term;
        logic [63:0] idx;
        logic [63:0] g;
        k = 64'(rq.set_size[ARG_BITS-1:0]);
        r = 64'(rq.choose_count[ARG_BITS-1:0]);
        rs.overflowed = 1'b0;
        if (r > k) begin
            rs.coefficient = '0;
            return rs;
        end
        if (r > k - r) r = k - r;
        acc = 64'd1;
        for (logic [63:0] s = 1; s <= r; s++) begin
            term = k - s + 1;
            idx = s;
            g = gcd64(term, idx);
            term = term / g;
            idx = idx / g;
            acc = acc / idx;
            if (acc > ALL_ONES / term) begin
                rs.coefficient = ALL_ONES;
                rs.overflowed = 1'b1;
                return rs;
            end
            acc = acc * term;
        end
        rs.coefficient = acc;
        return rs;
    endfunction

    always @(posedge i_clk) begin
        t_bcu_rsp want;
        int       bad;
        bad = 0;
        if (!i_rst_n) begin
            o_errors  <= 0;
            o_pending <= 0;
        end else begin
            if (i_in_valid && !i_in_stall) coef_q.push_back(binom(i_req));
            if (i_out_valid && !i_out_stall) begin
                if (coef_q.size() == 0) begin
                    $display("%0t: unexpected response coef=%0d ovf=%0b", $time,
                             i_rsp.coefficient, i_rsp.overflowed);
                    bad++;
                end else begin
                    want = coef_q.pop_front();
                    if (want.coefficient !== i_rsp.coefficient) begin
                        $display("%0t: coefficient expected %0d actual %0d", $time,
                                 want.coefficient, i_rsp.coefficient);
                        bad++;
                    end
                    if (want.overflowed !== i_rsp.overflowed) begin
                        $display("%0t: overflowed expected %0b actual %0b", $time,
                                 want.overflowed, i_rsp.overflowed);
                        bad++;
                    end
                end
            end
            if (bad != 0) o_errors <= o_errors + bad;
            o_pending <= coef_q.size();
        end
    end
endmodule

### test/binomial_coefficient_unit_tb.sv
// Testbench top for the binomial coefficient unit: stimulus, flow control and verdict.
module binomial_coefficient_unit_tb;
    import bcu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_in_valid = 1'b0;
    logic     o_in_stall;
    t_bcu_req i_req = '0;
    logic     o_out_valid;
    logic     i_out_stall = 1'b0;
    t_bcu_rsp o_rsp;
    int       errors;
    int       pending;
    int       send_idle_pct = 0;
    int       stall_pct = 0;
    int       hold_cycles = 0;
    logic     hold_req = 1'b0;
    logic     hold_used = 1'b0;

    binomial_coefficient_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_req(i_req), .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_rsp(o_rsp)
    );

    binomial_coefficient_unit_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid), .i_in_stall(o_in_stall),
        .i_req(i_req), .i_out_valid(o_out_valid), .i_out_stall(i_out_stall), .i_rsp(o_rsp),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver: random stalls plus a single long hold-off
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_stall <= 1'b1;
        end else if (hold_req && !hold_used) begin
            hold_cycles <= 2999;
            hold_used   <= 1'b1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_request(logic [15:0] k, logic [15:0] r);
        t_bcu_req rq;
        rq.set_size = k;
        rq.choose_count = r;
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_req <= rq;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_random();
        logic [15:0] k;
        logic [15:0] r;
        case ($urandom_range(9))
            0, 1, 2: begin
                k = 16'($urandom);
                r = 16'($urandom);
            end
            3, 4, 5: begin
                k = 16'($urandom);
                if ($urandom_range(1)) r = 16'($urandom_range(4));
                else r = k - 16'($urandom_range(4));
            end
            6, 7, 8: begin
                k = 16'($urandom_range(70));
                r = 16'($urandom_range(k + 2));
            end
            default: begin
                // around the point where the value leaves 64 bits
                k = 16'($urandom_range(200, 60));
                r = 16'($urandom_range(k / 2));
            end
        endcase
        send_request(k, r);
    endtask

    initial begin
        #1000ms;
        $display("Verification failed");
        $finish;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(16'd0, 16'd0);
        send_request(16'd0, 16'd1);
        send_request(16'd0, 16'hFFFF);
        send_request(16'd5, 16'd0);
        send_request(16'd5, 16'd5);
        send_request(16'd5, 16'd6);
        send_request(16'd5, 16'd2);
        send_request(16'hFFFF, 16'd0);
        send_request(16'hFFFF, 16'd1);
        send_request(16'hFFFF, 16'd2);
        send_request(16'hFFFF, 16'd3);
        send_request(16'hFFFF, 16'hFFFF);
        send_request(16'hFFFF, 16'hFFFE);
        send_request(16'hFFFF, 16'h8000);
        send_request(16'hFFFE, 16'hFFFF);
        send_request(16'd67, 16'd33);
        send_request(16'd68, 16'd34);
        send_request(16'd66, 16'd33);
        send_request(16'd62, 16'd31);
        send_request(16'd100, 16'd50);
        send_request(16'd1, 16'd1);
        send_request(16'h5555, 16'hAAAA);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 63; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 63; end
                default: begin send_idle_pct = 30; stall_pct = 30; end
            endcase
            for (int n = 0; n < 410; n++) begin
                if (ph == 0 && n == 20) hold_req <= 1'b1;
                send_random();
            end
        end
        i_in_valid <= 1'b0;
        @(posedge i_clk);

        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

### sim.f
sv/bcu_pkg.sv
sv/bcu_div.sv
sv/binomial_coefficient_unit.sv
test/binomial_coefficient_unit_checker.sv
test/binomial_coefficient_unit_tb.sv
